[rtl/core/pmf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmf_pkg: shared types and constants of the projective map engine
// Field widths, payload structures, the job record passed from the front
// to the back, and small index helpers.
// ----------------------------------------------------------------------------
package pmf_pkg;

  // Coordinate and result widths.
  localparam int unsigned CoordW   = 32;
  localparam int unsigned EntryW   = 48;
  localparam int unsigned ChunkW   = 32;

  // Exact intermediate widths.
  // A cofactor is a difference of two 62-bit products.
  localparam int unsigned CofW     = 65;
  // Determinant and weight sums stay below 2^96 in magnitude.
  localparam int unsigned SumW     = 98;
  localparam int unsigned DenW     = 97;
  // Accumulator holds |S| times a coordinate, below 2^127.
  localparam int unsigned AccW     = 130;
  // Multiplier operand, sign-extended and cut into four chunks.
  localparam int unsigned XW       = 128;
  // Numerator magnitude after the Q24.24 alignment shift.
  localparam int unsigned MagW     = 136;
  localparam int unsigned DirShift = 8;
  localparam int unsigned InvShift = 40;

  // Default depth of the job queue between front and back.
  localparam int unsigned DefQueueDepth = 2;

  // One input item: four homogeneous points in Q16.16.
  typedef struct packed {
    logic signed [CoordW-1:0] p_w;
    logic signed [CoordW-1:0] p_x;
    logic signed [CoordW-1:0] p_y;
    logic signed [CoordW-1:0] q_w;
    logic signed [CoordW-1:0] q_x;
    logic signed [CoordW-1:0] q_y;
    logic signed [CoordW-1:0] r_w;
    logic signed [CoordW-1:0] r_x;
    logic signed [CoordW-1:0] r_y;
    logic signed [CoordW-1:0] u_w;
    logic signed [CoordW-1:0] u_x;
    logic signed [CoordW-1:0] u_y;
  } pmf_in_t;

  // One result row.
  typedef struct packed {
    logic                     which_matrix;
    logic [1:0]               row_index;
    logic signed [EntryW-1:0] entry_0;
    logic signed [EntryW-1:0] entry_1;
    logic signed [EntryW-1:0] entry_2;
    logic                     singular;
    logic                     last_row;
  } pmf_out_t;

  // Exact quantities of one map, handed from the front to the back.
  typedef struct packed {
    logic                      sing;
    logic                      det_neg;
    logic [DenW-1:0]           det_mag;
    logic [2:0][DenW-1:0]      s_mag;
    logic [8:0][CofW-1:0]      cof;
    logic [8:0][AccW-1:0]      num;
  } pmf_job_t;

  // One division request.
  typedef struct packed {
    logic [MagW-1:0] mag;
    logic [DenW-1:0] den;
    logic            neg;
  } pmf_div_req_t;

  // Flat index of element (r, c) of a 3x3 matrix.
  function automatic logic [3:0] idx9(logic [1:0] r, logic [1:0] c);
    logic [3:0] rr;
    rr = {2'b00, r};
    return (rr << 1) + rr + {2'b00, c};
  endfunction

  // Successor modulo three.
  function automatic logic [1:0] nxt3(logic [1:0] v);
    logic [1:0] n;
    case (v)
      2'd0:    n = 2'd1;
      2'd1:    n = 2'd2;
      default: n = 2'd0;
    endcase
    return n;
  endfunction

endpackage

[rtl/core/pmf_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmf_if: input and output channels of the projective map engine
// Valid/ready channels; a transfer takes place when valid and ready are
// both high at a rising clock edge.
// ----------------------------------------------------------------------------
interface pmf_in_if;
  import pmf_pkg::*;
  logic    valid;
  logic    ready;
  pmf_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pmf_out_if;
  import pmf_pkg::*;
  logic     valid;
  logic     ready;
  pmf_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/projective_map_from_four_points.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// projective_map_from_four_points: plane projective map from four points
// Each input transfer carries four homogeneous points p, q, r, u in Q16.16.
// The block returns six rows in Q24.24: rows 0..2 of the direct matrix that
// takes the cardinal points to p, q, r and the unit point to u, then rows
// 0..2 of its inverse. All quantities are formed exactly and rounded once,
// half away from zero, with saturation to 48 bits; a zero determinant or a
// zero weight sets singular and zeroes the entries. The front works on its
// single 33x32 multiplier; the back runs eighteen divisions on one
// bit-serial divider, where a quotient that reaches 2^48 saturates at once,
// and a singular map needs no divisions. The input holding register and a
// job queue of two entries by default let the next item be taken and
// worked on while the back is still busy.
// ----------------------------------------------------------------------------
module projective_map_from_four_points #(
  parameter int unsigned QueueDepth = pmf_pkg::DefQueueDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pmf_in_if.sink    in_i,
  pmf_out_if.source out_o
);
  import pmf_pkg::*;

  logic     f_vld, f_rdy, b_vld, b_rdy;
  pmf_job_t f_job, b_job;

  // Front: exact products and sums.
  pmf_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .job_vld_o (f_vld),
    .job_rdy_i (f_rdy),
    .job_o     (f_job)
  );

  // Job queue.
  pmf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_vld_i (f_vld),
    .push_rdy_o (f_rdy),
    .push_i     (f_job),
    .pop_vld_o  (b_vld),
    .pop_rdy_i  (b_rdy),
    .pop_o      (b_job)
  );

  // Back: divisions and result rows.
  pmf_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .job_vld_i (b_vld),
    .job_rdy_o (b_rdy),
    .job_i     (b_job),
    .out_o     (out_o)
  );

endmodule

[rtl/core/pmf_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmf_front: exact cofactors, determinant, weights and direct numerators
// Takes an item into a holding register, then runs a fixed sequence of
// multiply-accumulate steps on one 33x32 multiplier and hands the results
// on as one job record.
// ----------------------------------------------------------------------------
module pmf_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  pmf_in_if.sink            in_i,
  output logic              job_vld_o,
  input  logic              job_rdy_i,
  output pmf_pkg::pmf_job_t job_o
);
  import pmf_pkg::*;

  typedef enum logic [5:0] {
    F_IDLE = 6'b000001,
    F_COF  = 6'b000010,
    F_DET  = 6'b000100,
    F_SUM  = 6'b001000,
    F_NUM  = 6'b010000,
    F_PUSH = 6'b100000
  } fstate_e;

  fstate_e st_q, st_d;
  logic    hold_vld_q, hold_vld_d;
  pmf_in_t hold_q;

  logic [1:0] ri_q, ri_d, ci_q, ci_d, term_q, term_d, chunk_q, chunk_d;
  logic       start, issue, last_chunk, last_term;

  logic signed [CoordW-1:0] a_q [3][3];
  logic signed [CoordW-1:0] u_q [3];
  logic signed [CofW-1:0]   cof_q [9];
  logic signed [SumW-1:0]   det_q;
  logic signed [SumW-1:0]   s_q [3];
  logic signed [AccW-1:0]   num_q [9];
  logic signed [AccW-1:0]   acc_q;

  // Multiplier stage.
  logic signed [XW-1:0]     x_op;
  logic signed [CoordW-1:0] y_op;
  logic                     sub_op;
  logic [ChunkW-1:0]        chunk_bits;
  logic signed [ChunkW:0]   mul_a;
  logic signed [64:0]       mul_p;
  logic [1:0]               r1, r2, c1, c2;
  logic signed [SumW-1:0]   s_abs;

  logic signed [64:0] prod_q;
  logic               p_vld_q, p_first_q, p_last_q, p_sub_q;
  logic [1:0]         p_chunk_q, p_ri_q, p_ci_q;
  fstate_e            p_cls_q;

  // Accumulator stage.
  logic signed [AccW-1:0] term_v, base_v, acc_sum;

  // Input holding register: a new item is taken while the previous one runs.
  assign in_i.ready = !hold_vld_q;

  always_comb begin
    hold_vld_d = hold_vld_q;
    if (in_i.valid && in_i.ready) begin
      hold_vld_d = 1'b1;
    end else if (start) begin
      hold_vld_d = 1'b0;
    end
  end

  // Step limits of each phase.
  always_comb begin
    case (st_q)
      F_COF:   begin last_chunk = (chunk_q == 2'd0); last_term = (term_q == 2'd1); end
      F_DET,
      F_SUM:   begin last_chunk = (chunk_q == 2'd2); last_term = (term_q == 2'd2); end
      F_NUM:   begin last_chunk = (chunk_q == 2'd3); last_term = 1'b1;             end
      default: begin last_chunk = 1'b1;              last_term = 1'b1;             end
    endcase
  end

  // Sequencer.
  always_comb begin
    st_d    = st_q;
    ri_d    = ri_q;
    ci_d    = ci_q;
    term_d  = term_q;
    chunk_d = chunk_q;
    start   = 1'b0;
    issue   = 1'b0;
    case (st_q)
      F_IDLE: begin
        if (hold_vld_q) begin
          start   = 1'b1;
          st_d    = F_COF;
          ri_d    = '0;
          ci_d    = '0;
          term_d  = '0;
          chunk_d = '0;
        end
      end
      F_COF, F_DET, F_SUM, F_NUM: begin
        issue = 1'b1;
        if (!last_chunk) begin
          chunk_d = chunk_q + 2'd1;
        end else begin
          chunk_d = '0;
          if (!last_term) begin
            term_d = term_q + 2'd1;
          end else begin
            term_d = '0;
            if (st_q == F_DET) begin
              st_d = F_SUM;
              ri_d = '0;
            end else if (st_q == F_SUM) begin
              if (ri_q == 2'd2) begin
                ri_d = '0;
                ci_d = '0;
                st_d = F_NUM;
              end else begin
                ri_d = ri_q + 2'd1;
              end
            end else if (ci_q != 2'd2) begin
              ci_d = ci_q + 2'd1;
            end else begin
              ci_d = '0;
              if (ri_q != 2'd2) begin
                ri_d = ri_q + 2'd1;
              end else begin
                ri_d = '0;
                st_d = (st_q == F_COF) ? F_DET : F_PUSH;
              end
            end
          end
        end
      end
      F_PUSH: begin
        if (job_vld_o && job_rdy_i) begin
          st_d = F_IDLE;
        end
      end
      default: st_d = F_IDLE;
    endcase
  end

  // Operand selection for the current product.
  always_comb begin
    r1     = nxt3(ri_q);
    r2     = nxt3(r1);
    c1     = nxt3(ci_q);
    c2     = nxt3(c1);
    s_abs  = s_q[ri_q][SumW-1] ? -s_q[ri_q] : s_q[ri_q];
    x_op   = '0;
    y_op   = '0;
    sub_op = 1'b0;
    case (st_q)
      F_COF: begin
        if (term_q == 2'd0) begin
          x_op = XW'(a_q[r1][c1]);
          y_op = a_q[r2][c2];
        end else begin
          x_op   = XW'(a_q[r1][c2]);
          y_op   = a_q[r2][c1];
          sub_op = 1'b1;
        end
      end
      F_DET: begin
        x_op = XW'(cof_q[idx9(2'd0, term_q)]);
        y_op = a_q[0][term_q];
      end
      F_SUM: begin
        x_op = XW'(cof_q[idx9(ri_q, term_q)]);
        y_op = u_q[term_q];
      end
      F_NUM: begin
        x_op = XW'(s_abs);
        y_op = a_q[ri_q][ci_q];
      end
      default: ;
    endcase
  end

  // Low chunks are unsigned, the last chunk of an operand carries its sign.
  assign chunk_bits = x_op[{chunk_q, 5'b00000} +: ChunkW];
  assign mul_a      = {last_chunk & chunk_bits[ChunkW-1], chunk_bits};
  assign mul_p      = 65'(mul_a) * 65'(y_op);

  // Chunk product, shifted into place and accumulated.
  always_comb begin
    term_v  = AccW'(prod_q) <<< {p_chunk_q, 5'b00000};
    base_v  = p_first_q ? '0 : acc_q;
    acc_sum = p_sub_q ? (base_v - term_v) : (base_v + term_v);
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= F_IDLE;
      hold_vld_q <= 1'b0;
      p_vld_q    <= 1'b0;
      ri_q       <= '0;
      ci_q       <= '0;
      term_q     <= '0;
      chunk_q    <= '0;
    end else begin
      st_q       <= st_d;
      hold_vld_q <= hold_vld_d;
      p_vld_q    <= issue;
      ri_q       <= ri_d;
      ci_q       <= ci_d;
      term_q     <= term_d;
      chunk_q    <= chunk_d;
    end
  end

  // Data registers.
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      hold_q <= in_i.data;
    end
    if (start) begin
      a_q[0][0] <= hold_q.p_w;  a_q[0][1] <= hold_q.p_x;  a_q[0][2] <= hold_q.p_y;
      a_q[1][0] <= hold_q.q_w;  a_q[1][1] <= hold_q.q_x;  a_q[1][2] <= hold_q.q_y;
      a_q[2][0] <= hold_q.r_w;  a_q[2][1] <= hold_q.r_x;  a_q[2][2] <= hold_q.r_y;
      u_q[0]    <= hold_q.u_w;  u_q[1]    <= hold_q.u_x;  u_q[2]    <= hold_q.u_y;
    end
    prod_q    <= mul_p;
    p_first_q <= (term_q == 2'd0) && (chunk_q == 2'd0);
    p_last_q  <= last_term && last_chunk;
    p_sub_q   <= sub_op;
    p_chunk_q <= chunk_q;
    p_ri_q    <= ri_q;
    p_ci_q    <= ci_q;
    p_cls_q   <= st_q;
    if (p_vld_q) begin
      acc_q <= acc_sum;
      if (p_last_q) begin
        case (p_cls_q)
          F_COF:   cof_q[idx9(p_ri_q, p_ci_q)] <= acc_sum[CofW-1:0];
          F_DET:   det_q                       <= acc_sum[SumW-1:0];
          F_SUM:   s_q[p_ri_q]                 <= acc_sum[SumW-1:0];
          F_NUM:   num_q[idx9(p_ri_q, p_ci_q)] <= acc_sum;
          default: ;
        endcase
      end
    end
  end

  // Job record: the last accumulation has landed once the product stage is empty.
  logic signed [SumW-1:0] det_abs;
  logic signed [SumW-1:0] sm_abs [3];

  assign job_vld_o = (st_q == F_PUSH) && !p_vld_q;

  always_comb begin
    det_abs       = det_q[SumW-1] ? -det_q : det_q;
    job_o.sing    = (det_q == '0);
    job_o.det_neg = det_q[SumW-1];
    job_o.det_mag = det_abs[DenW-1:0];
    for (int k = 0; k < 3; k++) begin
      sm_abs[k]        = s_q[k][SumW-1] ? -s_q[k] : s_q[k];
      job_o.s_mag[k]   = sm_abs[k][DenW-1:0];
      if (s_q[k] == '0) begin
        job_o.sing = 1'b1;
      end
    end
    for (int k = 0; k < 9; k++) begin
      job_o.cof[k] = cof_q[k];
      job_o.num[k] = num_q[k];
    end
  end

endmodule

[rtl/core/pmf_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmf_queue: short job queue between the front and the back
// A small first-in first-out buffer of job records.
// ----------------------------------------------------------------------------
module pmf_queue #(
  parameter int unsigned Depth = pmf_pkg::DefQueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_vld_i,
  output logic              push_rdy_o,
  input  pmf_pkg::pmf_job_t push_i,
  output logic              pop_vld_o,
  input  logic              pop_rdy_i,
  output pmf_pkg::pmf_job_t pop_o
);
  import pmf_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  pmf_job_t        mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign push_rdy_o = (cnt_q != CntW'(Depth));
  assign pop_vld_o  = (cnt_q != '0);
  assign push       = push_vld_i && push_rdy_o;
  assign pop        = pop_vld_o && pop_rdy_i;
  assign pop_o      = mem_q[rd_q];

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_i;
    end
  end

endmodule

[rtl/core/pmf_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmf_div: rounding, saturating bit-serial divider
// Computes floor((2n + d) / 2d), which is n / d rounded half away from
// zero, one quotient bit a cycle, and saturates to 48-bit signed.
// ----------------------------------------------------------------------------
module pmf_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  pmf_pkg::pmf_div_req_t       req_i,
  output logic                        idle_o,
  output logic                        done_o,
  output logic signed [pmf_pkg::EntryW-1:0] quo_o
);
  import pmf_pkg::*;

  localparam int unsigned NumW = MagW + 2;
  localparam int unsigned RemW = DenW + 1;
  localparam int unsigned CntW = $clog2(EntryW);

  typedef enum logic [3:0] {
    D_IDLE = 4'b0001,
    D_CHK  = 4'b0010,
    D_RUN  = 4'b0100,
    D_FIN  = 4'b1000
  } dstate_e;

  dstate_e           st_q;
  logic [CntW-1:0]   cnt_q;
  logic [NumW-1:0]   num_q;
  logic [RemW-1:0]   den_q, rem_q;
  logic [EntryW-1:0] low_q, quo_q;
  logic              neg_q;

  logic              over;
  logic [RemW:0]     trial, diff;
  logic              ge;
  logic [EntryW-1:0] lim, mag;

  assign idle_o = (st_q == D_IDLE);
  assign done_o = (st_q == D_FIN);

  // Quotient of 2^48 or more saturates without iterating.
  assign over  = (NumW + EntryW)'(num_q) >= {(NumW + EntryW - RemW - EntryW)'(0), den_q,
                                             EntryW'(0)};
  assign trial = {rem_q, low_q[EntryW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});

  // Saturation and sign.
  always_comb begin
    lim   = neg_q ? {1'b1, (EntryW - 1)'(0)} : {1'b0, {(EntryW - 1){1'b1}}};
    mag   = (quo_q > lim) ? lim : quo_q;
    quo_o = neg_q ? -$signed(mag) : $signed(mag);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= D_IDLE;
      cnt_q <= '0;
    end else begin
      case (st_q)
        D_IDLE:  if (start_i) st_q <= D_CHK;
        D_CHK: begin
          cnt_q <= '0;
          st_q  <= over ? D_FIN : D_RUN;
        end
        D_RUN: begin
          cnt_q <= cnt_q + CntW'(1);
          if (cnt_q == CntW'(EntryW - 1)) begin
            st_q <= D_FIN;
          end
        end
        D_FIN:   st_q <= D_IDLE;
        default: st_q <= D_IDLE;
      endcase
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    case (st_q)
      D_IDLE: begin
        if (start_i) begin
          num_q <= (NumW'(req_i.mag) << 1) + NumW'(req_i.den);
          den_q <= {req_i.den, 1'b0};
          neg_q <= req_i.neg;
        end
      end
      D_CHK: begin
        rem_q <= RemW'(num_q[NumW-1:EntryW]);
        low_q <= num_q[EntryW-1:0];
        quo_q <= over ? '1 : '0;
      end
      D_RUN: begin
        rem_q <= ge ? diff[RemW-1:0] : trial[RemW-1:0];
        low_q <= {low_q[EntryW-2:0], 1'b0};
        quo_q <= {quo_q[EntryW-2:0], ge};
      end
      default: ;
    endcase
  end

endmodule

[rtl/core/pmf_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmf_back: division sequencing and result rows
// Takes the job at the head of the queue, runs the eighteen divisions of
// the direct and inverse matrices and emits six rows through an output
// register.
// ----------------------------------------------------------------------------
module pmf_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_vld_i,
  output logic              job_rdy_o,
  input  pmf_pkg::pmf_job_t job_i,
  pmf_out_if.source         out_o
);
  import pmf_pkg::*;

  typedef enum logic [3:0] {
    B_IDLE  = 4'b0001,
    B_START = 4'b0010,
    B_WAIT  = 4'b0100,
    B_OUT   = 4'b1000
  } bstate_e;

  bstate_e                  st_q;
  logic                     which_q;
  logic [1:0]               row_q, col_q;
  logic signed [EntryW-1:0] ent_q [3];
  logic                     out_vld_q;
  pmf_out_t                 out_q;

  logic                     div_start, div_idle, div_done;
  logic signed [EntryW-1:0] div_quo;
  pmf_div_req_t             req;
  logic [3:0]               idx;
  logic signed [AccW-1:0]   nv;
  logic signed [CofW-1:0]   cv;
  logic [AccW-1:0]          n_abs;
  logic [CofW-1:0]          c_abs;
  logic                     out_load, last;
  pmf_out_t                 row;

  // Division operands of entry (row, col).
  always_comb begin
    idx   = which_q ? idx9(col_q, row_q) : idx9(row_q, col_q);
    nv    = $signed(job_i.num[idx]);
    cv    = $signed(job_i.cof[idx]);
    n_abs = nv[AccW-1] ? -nv : nv;
    c_abs = cv[CofW-1] ? -cv : cv;
    if (!which_q) begin
      req.mag = MagW'(n_abs) << DirShift;
      req.den = job_i.det_mag;
      req.neg = nv[AccW-1];
    end else begin
      req.mag = MagW'(c_abs) << InvShift;
      req.den = job_i.s_mag[col_q];
      req.neg = cv[CofW-1] ^ job_i.det_neg;
    end
  end

  assign div_start = (st_q == B_START);

  pmf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .req_i   (req),
    .idle_o  (div_idle),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Row assembly; a degenerate map gives zero entries.
  always_comb begin
    last             = which_q && (row_q == 2'd2);
    row.which_matrix = which_q;
    row.row_index    = row_q;
    row.entry_0      = job_i.sing ? '0 : ent_q[0];
    row.entry_1      = job_i.sing ? '0 : ent_q[1];
    row.entry_2      = job_i.sing ? '0 : ent_q[2];
    row.singular     = job_i.sing;
    row.last_row     = last;
  end

  assign out_load    = (st_q == B_OUT) && (!out_vld_q || out_o.ready);
  assign job_rdy_o   = out_load && last;
  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= B_IDLE;
      which_q   <= 1'b0;
      row_q     <= '0;
      col_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
      case (st_q)
        B_IDLE: begin
          if (job_vld_i) begin
            which_q <= 1'b0;
            row_q   <= '0;
            col_q   <= '0;
            st_q    <= job_i.sing ? B_OUT : B_START;
          end
        end
        B_START: st_q <= B_WAIT;
        B_WAIT: begin
          if (div_done) begin
            if (col_q == 2'd2) begin
              st_q <= B_OUT;
            end else begin
              col_q <= col_q + 2'd1;
              st_q  <= B_START;
            end
          end
        end
        B_OUT: begin
          if (out_load) begin
            col_q <= '0;
            if (last) begin
              st_q <= B_IDLE;
            end else begin
              if (row_q == 2'd2) begin
                which_q <= 1'b1;
                row_q   <= '0;
              end else begin
                row_q <= row_q + 2'd1;
              end
              st_q <= job_i.sing ? B_OUT : B_START;
            end
          end
        end
        default: st_q <= B_IDLE;
      endcase
    end
  end

  // Row buffer and output register.
  always_ff @(posedge clk_i) begin
    if ((st_q == B_WAIT) && div_done) begin
      ent_q[col_q] <= div_quo;
    end
    if (out_load) begin
      out_q <= row;
    end
  end

  // The job is released only while one is present.
  assert property (@(posedge clk_i) disable iff (!rst_ni) job_rdy_o |-> job_vld_i)
    else $error("job released from an empty queue");

  // A division is only started on an idle divider.
  assert property (@(posedge clk_i) disable iff (!rst_ni) div_start |-> div_idle)
    else $error("division started while the divider is busy");

  // Degenerate maps carry zero entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_vld_q && out_q.singular |->
      (out_q.entry_0 == '0) && (out_q.entry_1 == '0) && (out_q.entry_2 == '0))
    else $error("singular row with non-zero entries");

  // The final row is row two of the inverse matrix.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_vld_q && out_q.last_row |-> out_q.which_matrix && (out_q.row_index == 2'd2))
    else $error("final row flag on the wrong row");

endmodule
